// ----- hdl/mask_bounding_box_core_assert.svh -----
// Assertion macros for the checker module of the mask bounding box core.
// Depends on nothing; included by the checker module.
`ifndef MASK_BOUNDING_BOX_CORE_ASSERT_SVH
`define MASK_BOUNDING_BOX_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define MBB_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define MBB_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mbb_pkg.sv -----
// Shared types, constants and helpers for the mask bounding box core.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package mbb_pkg;

    // Geometry limits
    localparam int MAX_DIM = 4096;
    localparam int LANES   = 8;
    localparam int LANE_W  = $clog2(LANES);
    localparam int DIM_W   = 13;              // width of the dimension registers
    localparam int COL_W   = 12;              // pixel column / row index
    localparam int EDGE_W  = 13;              // exclusive right / bottom edge
    localparam int BCOL_W  = 9;               // byte index within a row
    localparam int RBYTE_W = BCOL_W + 1;      // bytes per row, up to 512

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // What the merging stage found in one byte
    typedef struct packed {
        logic             hit;      // some visible pixel in the byte
        logic [COL_W-1:0] lo_col;   // leftmost visible column
        logic [COL_W-1:0] hi_col;   // rightmost visible column
    } t_merge_res;

    // Out-of-range dimensions: zero acts as one, anything past the limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mask_bounding_box_core.sv -----
// Top level of the mask bounding box core: frame counters, bounds and result register.
// Depends on mbb_pkg, mbb_lane and mbb_merge.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | sink      | i_in_valid / o_in_ready | i_mask_byte
//  out     | source    | o_out_valid/i_out_ready | o_found, o_left_edge, o_top_edge,
//          |           |                         | o_right_edge, o_bottom_edge
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One mask byte is taken every cycle; eight lanes and the merge stage settle it combinationally.
// The result shows in the output register on the cycle after the last byte of a frame.
// Only the last byte of a frame waits, and only while an earlier result is still held.
// Synchronous active-low reset clears counters, bounds and the output valid; sizes become 1.
`default_nettype none

module mask_bounding_box_core
    import mbb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // mask byte requests
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_mask_byte,
    // result requests
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_found,
    output logic [COL_W-1:0]          o_left_edge,
    output logic [COL_W-1:0]          o_top_edge,
    output logic [EDGE_W-1:0]         o_right_edge,
    output logic [EDGE_W-1:0]         o_bottom_edge,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;

    // Frame state
    logic [BCOL_W-1:0] r_byte_col, n_byte_col;
    logic [COL_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_min_col, n_min_col;
    logic [COL_W-1:0]  r_max_col, n_max_col;
    logic [COL_W-1:0]  r_min_row, n_min_row;
    logic [COL_W-1:0]  r_max_row, n_max_row;
    logic              r_any, n_any;

    // Result register
    logic              r_out_valid;
    logic              r_found;
    logic [COL_W-1:0]  r_left;
    logic [COL_W-1:0]  r_top;
    logic [EDGE_W-1:0] r_right;
    logic [EDGE_W-1:0] r_bottom;

    logic [DIM_W-1:0]   w_width;
    logic [DIM_W-1:0]   w_height;
    logic [RBYTE_W-1:0] w_row_bytes;
    logic               w_last_byte;
    logic               w_last_row;
    logic               w_frame_end;
    logic               w_in_fire;
    logic [COL_W-1:0]   w_base_col;

    logic [LANES-1:0]            w_visible;
    logic [LANES-1:0][COL_W-1:0] w_column;
    t_merge_res                  w_merge;

    // Effective sizes and row / frame boundaries
    assign w_width     = clamp_dim(r_width);
    assign w_height    = clamp_dim(r_height);
    assign w_row_bytes = RBYTE_W'((w_width + DIM_W'(LANES - 1)) >> LANE_W);
    assign w_last_byte = ({1'b0, r_byte_col} + RBYTE_W'(1)) >= w_row_bytes;
    assign w_last_row  = ({1'b0, r_row} + DIM_W'(1)) >= w_height;
    assign w_frame_end = w_last_byte && w_last_row;
    assign w_base_col  = {r_byte_col, {LANE_W{1'b0}}};

    // Only a frame-closing byte needs room in the result register
    assign o_in_ready  = !w_frame_end || !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Pixel lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mbb_lane u_lane (
            .i_pixel     (i_mask_byte[g]),
            .i_lane_idx  (LANE_W'(g)),
            .i_base_col  (w_base_col),
            .i_last_byte (w_last_byte),
            .i_width_rem (w_width[LANE_W-1:0]),
            .o_visible   (w_visible[g]),
            .o_column    (w_column[g])
        );
    end

    mbb_merge u_merge (
        .i_visible (w_visible),
        .i_column  (w_column),
        .o_res     (w_merge)
    );

    // Bounds and position after this byte
    always_comb begin
        n_min_col  = r_min_col;
        n_max_col  = r_max_col;
        n_min_row  = r_min_row;
        n_max_row  = r_max_row;
        n_any      = r_any;
        n_byte_col = r_byte_col;
        n_row      = r_row;
        if (w_merge.hit) begin
            n_any = 1'b1;
            if (!r_any) begin
                n_min_col = w_merge.lo_col;
                n_max_col = w_merge.hi_col;
                n_min_row = r_row;
                n_max_row = r_row;
            end else begin
                if (w_merge.lo_col < r_min_col) n_min_col = w_merge.lo_col;
                if (w_merge.hi_col > r_max_col) n_max_col = w_merge.hi_col;
                if (r_row < r_min_row)          n_min_row = r_row;
                if (r_row > r_max_row)          n_max_row = r_row;
            end
        end
        if (w_last_byte) begin
            n_byte_col = '0;
            n_row      = r_row + COL_W'(1);
        end else begin
            n_byte_col = r_byte_col + BCOL_W'(1);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IMAGE_WIDTH)  r_width  <= i_cfg_data;
            if (i_cfg_index == CFG_IMAGE_HEIGHT) r_height <= i_cfg_data;
        end
    end

    // Frame state: cleared at reset and after each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_in_fire && w_frame_end)) begin
            r_byte_col <= '0;
            r_row      <= '0;
            r_min_col  <= '1;
            r_max_col  <= '0;
            r_min_row  <= '1;
            r_max_row  <= '0;
            r_any      <= 1'b0;
        end else if (w_in_fire) begin
            r_byte_col <= n_byte_col;
            r_row      <= n_row;
            r_min_col  <= n_min_col;
            r_max_col  <= n_max_col;
            r_min_row  <= n_min_row;
            r_max_row  <= n_max_row;
            r_any      <= n_any;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire && w_frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; edges read zero when nothing was found
    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_frame_end) begin
            r_found  <= n_any;
            r_left   <= n_any ? n_min_col : '0;
            r_top    <= n_any ? n_min_row : '0;
            r_right  <= n_any ? ({1'b0, n_max_col} + EDGE_W'(1)) : '0;
            r_bottom <= n_any ? ({1'b0, n_max_row} + EDGE_W'(1)) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_left_edge   = r_left;
    assign o_top_edge    = r_top;
    assign o_right_edge  = r_right;
    assign o_bottom_edge = r_bottom;

endmodule

`default_nettype wire

// ----- hdl/mbb_lane.sv -----
// One pixel lane: decides whether its bit of the mask byte counts and forms its column.
// Depends on mbb_pkg.
`default_nettype none

module mbb_lane
    import mbb_pkg::*;
(
    input  wire logic              i_pixel,
    input  wire logic [LANE_W-1:0] i_lane_idx,
    input  wire logic [COL_W-1:0]  i_base_col,
    input  wire logic              i_last_byte,
    input  wire logic [LANE_W-1:0] i_width_rem,
    output logic                   o_visible,
    output logic [COL_W-1:0]       o_column
);

    logic w_padding;

    // Bits at or past the width remainder in the last byte of a row are padding
    assign w_padding = i_last_byte && (i_width_rem != '0) && (i_lane_idx >= i_width_rem);
    assign o_visible = i_pixel && !w_padding;
    assign o_column  = {i_base_col[COL_W-1:LANE_W], i_lane_idx};

endmodule

`default_nettype wire

// ----- hdl/mbb_merge.sv -----
// Merging stage: picks the leftmost and rightmost visible lane of one byte.
// Depends on mbb_pkg.
`default_nettype none

module mbb_merge
    import mbb_pkg::*;
(
    input  wire logic [LANES-1:0]            i_visible,
    input  wire logic [LANES-1:0][COL_W-1:0] i_column,
    output t_merge_res                       o_res
);

    // Priority pick in both directions over the eight lanes
    always_comb begin
        o_res.hit    = |i_visible;
        o_res.lo_col = i_column[0];
        o_res.hi_col = i_column[0];
        for (int b = LANES - 1; b >= 0; b--) begin
            if (i_visible[b]) begin
                o_res.lo_col = i_column[b];
            end
        end
        for (int b = 0; b < LANES; b++) begin
            if (i_visible[b]) begin
                o_res.hi_col = i_column[b];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mbb_checker.sv -----
// Port-level checks for the mask bounding box core, bound to the top level.
// Depends on mbb_pkg and mask_bounding_box_core_assert.svh.
`default_nettype none

`include "mask_bounding_box_core_assert.svh"

module mbb_checker
    import mbb_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic                 o_found,
    input wire logic [COL_W-1:0]     o_left_edge,
    input wire logic [COL_W-1:0]     o_top_edge,
    input wire logic [EDGE_W-1:0]    o_right_edge,
    input wire logic [EDGE_W-1:0]    o_bottom_edge
);

    logic w_held;
    logic w_empty;
    logic w_full;
    logic w_zero_edges;
    logic w_ordered;

    // Result channel conditions
    assign w_held       = o_out_valid && !i_out_ready;
    assign w_empty      = o_out_valid && !o_found;
    assign w_full       = o_out_valid && o_found;
    assign w_zero_edges = (o_left_edge == '0) && (o_top_edge == '0) &&
                          (o_right_edge == '0) && (o_bottom_edge == '0);
    assign w_ordered    = ({1'b0, o_left_edge} < o_right_edge) &&
                          ({1'b0, o_top_edge} < o_bottom_edge);

    // A held result is not dropped
    `MBB_ASSERT_NXT(a_out_hold, i_clk, !i_rst_n, w_held, o_out_valid, "result dropped on stall")

    // Empty frame reports a zero rectangle
    `MBB_ASSERT_IMP(a_empty_zero, i_clk, !i_rst_n, w_empty, w_zero_edges, "empty box with edges")

    // A found rectangle is never empty
    `MBB_ASSERT_IMP(a_rect_order, i_clk, !i_rst_n, w_full, w_ordered, "box edges out of order")

    // No result right after reset
    `MBB_ASSERT_NXT(a_reset_idle, i_clk, 1'b0, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind mask_bounding_box_core mbb_checker u_mbb_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for mask_bounding_box_core: streams mask frames, predicts each box.
// Depends on mbb_pkg and the mask_bounding_box_core RTL; needs nothing else.
module tb_top;
    import mbb_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 16;
    localparam int RANDOM_BYTES   = 850;
    localparam int LIMIT_CYCLES   = 2_000_000;

    // register indexes the block does not map; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum int {PACE_STEADY, PACE_LIGHT, PACE_HEAVY} t_pace;
    typedef enum int {READY_ALWAYS, READY_PATTERN, READY_COIN} t_ready;
    typedef enum int {FILL_EMPTY, FILL_SPARSE, FILL_DENSE} t_fill;

    typedef struct packed {
        logic              found;
        logic [COL_W-1:0]  left;
        logic [COL_W-1:0]  top;
        logic [EDGE_W-1:0] right;
        logic [EDGE_W-1:0] bottom;
    } t_box;

    // DUT connections; the inputs are known from time zero
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_mask_byte  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    logic                 o_found;
    logic [COL_W-1:0]     o_left_edge;
    logic [COL_W-1:0]     o_top_edge;
    logic [EDGE_W-1:0]    o_right_edge;
    logic [EDGE_W-1:0]    o_bottom_edge;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [DIM_W-1:0]     i_cfg_data   = '0;

    mask_bounding_box_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mask_byte   (i_mask_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_left_edge   (o_left_edge),
        .o_top_edge    (o_top_edge),
        .o_right_edge  (o_right_edge),
        .o_bottom_edge (o_bottom_edge),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow registers and frame state of the box tracker
    logic [DIM_W-1:0]  width_reg  = DIM_W'(1);
    logic [DIM_W-1:0]  height_reg = DIM_W'(1);
    logic [BCOL_W-1:0] byte_col;
    logic [COL_W-1:0]  row_cnt;
    logic [COL_W-1:0]  min_col, max_col, min_row, max_row;
    logic              seen_any;

    t_box        boxes_due[$];
    logic [7:0]  bytes_pending[$];

    int unsigned pushed_count = 0;
    int unsigned taken_count  = 0;
    int unsigned boxes_checked = 0;
    int unsigned reg_writes   = 0;
    int unsigned errors       = 0;

    bit          in_taken     = 1'b0;
    bit          cfg_taken    = 1'b0;
    bit          holdoff_req  = 1'b0;
    t_pace       sender_pace  = PACE_STEADY;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // zero and oversize register values act as 1 and MAX_DIM
    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic void clear_box_state();
        byte_col = '0;
        row_cnt  = '0;
        min_col  = '1;
        max_col  = '0;
        min_row  = '1;
        max_row  = '0;
        seen_any = 1'b0;
    endfunction

    // fold one accepted mask byte into the running box; queue a box at frame end
    function automatic void fold_byte(input logic [7:0] pix_in);
        int unsigned w, h, row_bytes, base, lo, hi;
        int          b;
        logic [7:0]  pix;
        bit          last_in_row;
        t_box        box;
        w           = eff_dim(width_reg);
        h           = eff_dim(height_reg);
        row_bytes   = (w + 7) >> 3;
        base        = int'(byte_col) << 3;
        last_in_row = (int'(byte_col) + 1 >= row_bytes);
        pix         = pix_in;
        // padding columns past the width never count
        if (last_in_row && (w % 8) != 0) pix = pix & ((8'd1 << (w % 8)) - 8'd1);
        if (pix != '0) begin
            lo = 0;
            hi = 0;
            for (b = 7; b >= 0; b--) if (pix[b]) lo = b;
            for (b = 0; b < 8; b++) if (pix[b]) hi = b;
            if (!seen_any) begin
                min_col  = COL_W'(base + lo);
                max_col  = COL_W'(base + hi);
                min_row  = row_cnt;
                max_row  = row_cnt;
                seen_any = 1'b1;
            end else begin
                if (base + lo < min_col) min_col = COL_W'(base + lo);
                if (base + hi > max_col) max_col = COL_W'(base + hi);
                if (row_cnt < min_row) min_row = row_cnt;
                if (row_cnt > max_row) max_row = row_cnt;
            end
        end
        if (!last_in_row) begin
            byte_col = byte_col + 1'b1;
            return;
        end
        byte_col = '0;
        if (int'(row_cnt) + 1 < h) begin
            row_cnt = row_cnt + 1'b1;
            return;
        end
        box = '0;
        if (seen_any) begin
            box.found  = 1'b1;
            box.left   = min_col;
            box.top    = min_row;
            box.right  = EDGE_W'(max_col) + 1'b1;
            box.bottom = EDGE_W'(max_row) + 1'b1;
        end
        boxes_due.push_back(box);
        clear_box_state();
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: results checked first, then mask and register requests update the model
    always @(posedge i_clk) begin
        t_box want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (boxes_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual found=%0d",
                             $time, o_found);
                    errors++;
                end else begin
                    want = boxes_due.pop_front();
                    check_field("found", want.found, o_found);
                    check_field("left_edge", want.left, o_left_edge);
                    check_field("top_edge", want.top, o_top_edge);
                    check_field("right_edge", want.right, o_right_edge);
                    check_field("bottom_edge", want.bottom, o_bottom_edge);
                    boxes_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                fold_byte(i_mask_byte);
                taken_count++;
                in_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  = i_cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
                cfg_taken = 1'b1;
            end
        end
    end

    // mask driver: bursts of requests with gaps whose size follows the pace
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (bytes_pending.size() != 0) begin
                i_mask_byte <= bytes_pending.pop_front();
                i_in_valid  <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    case (sender_pace)
                        PACE_STEADY: gap_left = 0;
                        PACE_LIGHT:  gap_left = $urandom_range(0, 3);
                        default:     gap_left = $urandom_range(1, 12);
                    endcase
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver: its own stall pattern, plus a long hold-off on request
    int unsigned hold_left   = 0;
    int unsigned mode_left   = 0;
    int unsigned pat_pos     = 0;
    logic [15:0] stall_pattern = '1;
    t_ready      ready_mode  = READY_ALWAYS;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (holdoff_req) begin
                hold_left   = HOLDOFF_CYCLES;
                holdoff_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode    = t_ready'($urandom_range(0, 2));
                    stall_pattern = $urandom;
                    mode_left     = $urandom_range(16, 96);
                end
                mode_left--;
                pat_pos++;
                case (ready_mode)
                    READY_ALWAYS:  i_out_ready <= 1'b1;
                    READY_PATTERN: i_out_ready <= stall_pattern[pat_pos % 16];
                    default:       i_out_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // hard stop in case the block hangs
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("%0t: run timed out", $time);
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic queue_byte(input logic [7:0] b);
        bytes_pending.push_back(b);
        pushed_count++;
    endtask

    function automatic logic [7:0] pick_byte(input t_fill fill);
        case (fill)
            FILL_EMPTY:  return 8'h00;
            FILL_SPARSE: return ($urandom_range(0, 5) == 0) ?
                                (8'd1 << $urandom_range(0, 7)) | 8'($urandom & $urandom) : 8'h00;
            default:     return 8'($urandom);
        endcase
    endfunction

    // one whole frame at the current sizes, optionally with a fixed last byte
    task automatic queue_frame(input t_fill fill, input bit pin_last, input logic [7:0] last_val);
        int unsigned n, k;
        n = ((eff_dim(width_reg) + 7) >> 3) * eff_dim(height_reg);
        for (k = 0; k < n; k++) begin
            if (pin_last && k == n - 1) queue_byte(last_val);
            else queue_byte(pick_byte(fill));
        end
    endtask

    // every mask request taken and every box delivered
    task automatic wait_drained();
        do @(negedge i_clk); while (taken_count != pushed_count || boxes_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        cfg_taken = 1'b0;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // sizes change only with the block idle
    task automatic apply_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    // stimulus
    initial begin
        int unsigned      random_bytes, nframes, pause_at, f, start;
        logic [DIM_W-1:0] w, h;
        t_fill            fill;

        clear_box_state();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes 1x1: empty, full, padding-only and single-pixel frames
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'hFE);
        queue_byte(8'h01);

        // 13 wide, 2 high: two bytes per row, three padding bits per row
        apply_dims(DIM_W'(13), DIM_W'(2));
        queue_byte(8'h80); queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h10);
        queue_byte(8'h00); queue_byte(8'hE0); queue_byte(8'h00); queue_byte(8'hE0);
        queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h1F);

        // width a multiple of eight: no padding at all
        apply_dims(DIM_W'(8), DIM_W'(1));
        queue_byte(8'hFF);
        queue_byte(8'h81);

        // unmapped indexes leave both sizes alone
        wait_drained();
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        queue_byte(8'h7E);

        // zero width acts as 1: only bit 0 of each byte counts
        apply_dims('0, DIM_W'(6));
        queue_frame(FILL_SPARSE, 1'b1, 8'hFF);

        // oversize width, zero height: right edge at the limit
        apply_dims('1, '0);
        queue_frame(FILL_SPARSE, 1'b1, 8'h80);

        // receiver holds off while one-byte frames keep coming, then the sender waits
        apply_dims(DIM_W'(1), DIM_W'(1));
        sender_pace = PACE_STEADY;
        holdoff_req = 1'b1;
        repeat (40) queue_byte(pick_byte(FILL_DENSE));
        wait_drained();
        repeat (40) queue_byte(pick_byte(FILL_DENSE));

        // random sizes and frames
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            case ($urandom_range(0, 7))
                0:       w = DIM_W'($urandom_range(41, 300));
                1:       w = '0;
                default: w = DIM_W'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 9))
                0:       h = '0;
                1:       h = DIM_W'((w > 40) ? $urandom_range(1, 3) : $urandom_range(7, 12));
                default: h = DIM_W'((w > 40) ? $urandom_range(1, 2) : $urandom_range(1, 6));
            endcase
            apply_dims(w, h);
            sender_pace = t_pace'($urandom_range(0, 2));
            nframes  = $urandom_range(2, 8);
            pause_at = ($urandom_range(0, 3) == 0) ? nframes / 2 : nframes;
            start    = pushed_count;
            for (f = 0; f < nframes; f++) begin
                if (f == pause_at) wait_drained();
                case ($urandom_range(0, 7))
                    0:       fill = FILL_EMPTY;
                    1, 2, 3: fill = FILL_SPARSE;
                    default: fill = FILL_DENSE;
                endcase
                queue_frame(fill, 1'b0, 8'h00);
            end
            random_bytes += pushed_count - start;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (boxes_due.size() != 0) begin
            $display("%0t: %0d boxes expected, none arrived", $time, boxes_due.size());
            errors++;
        end
        $display("covered %0d mask bytes, %0d boxes checked, %0d register writes",
                 taken_count, boxes_checked, reg_writes);
        $display("small and random sizes, width at the limit, out-of-range sizes, padding,");
        $display("receiver stalls, a long hold-off and sender pauses");
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ----- mask_bounding_box_core.f -----
+incdir+hdl
hdl/mbb_pkg.sv
hdl/mbb_lane.sv
hdl/mbb_merge.sv
hdl/mask_bounding_box_core.sv
hdl/mbb_checker.sv
tb/sv/tb_top.sv
